// ===== hdl/hsv_color_group_classifier_core_assert.svh =====
// Assertion macros used by the checker of the classifier.
// The sampling clock is clk and the checks are off while rst_n is low.
`ifndef HSV_COLOR_GROUP_CLASSIFIER_CORE_ASSERT_SVH
`define HSV_COLOR_GROUP_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication.
`define HCGC_IMPLY(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hcgc check failed");

// Next-cycle implication.
`define HCGC_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hcgc check failed");

`endif

// ===== hdl/hcgc_pkg.sv =====
`timescale 1ns / 1ps
package hcgc_pkg;

    localparam int TABLE_SIZE  = 12;
    localparam int WEIGHT_BITS = 19;
    localparam int SUM_W       = WEIGHT_BITS + 17;
    localparam int TOT_W       = WEIGHT_BITS + 3;
    localparam int SCORE_W     = 17;
    localparam int DIFF_W      = 14;
    localparam int NUM_W       = 30;
    localparam int RECIP_SHIFT = 43;

    localparam logic [3:0]         MISC_CODE  = 4'd12;
    localparam logic [SCORE_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [14:0]        SCORE_SPAN = 15'd9180;
    localparam logic [14:0]        HALF_SPAN  = 15'd4590;
    localparam logic [4:0]         DEG_UNITS  = 5'd17;
    // floor(2^43 / 9180)
    localparam logic [29:0]        RECIP_M    = 30'd958180067;
    localparam logic [9:0]         FULL_TURN  = 10'd360;

    typedef struct packed {
        logic [8:0]             hue;
        logic [7:0]             saturation;
        logic [7:0]             brightness;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   last;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         group_index;
        logic [SCORE_W-1:0] score;
    } out_item_t;

    // Queue entry: saturation and brightness already scaled to 1/3060 units.
    typedef struct packed {
        logic [8:0]             hue;
        logic [11:0]            sat12;
        logic [11:0]            bri12;
        logic [WEIGHT_BITS-1:0] weight;
        logic                   last;
    } work_t;

    typedef struct packed {
        logic [8:0]  hlo;
        logic [8:0]  hhi;
        logic [11:0] slo;
        logic [11:0] shi;
        logic [11:0] blo;
        logic [11:0] bhi;
    } box_t;

    function automatic box_t get_box(input logic [3:0] idx);
        box_t bx;
        case (idx)
            4'd0:    bx = '{9'd200, 9'd260, 12'd918,  12'd3060, 12'd918,  12'd3060};
            4'd1:    bx = '{9'd340, 9'd20,  12'd918,  12'd3060, 12'd918,  12'd3060};
            4'd2:    bx = '{9'd80,  9'd140, 12'd918,  12'd3060, 12'd918,  12'd3060};
            4'd3:    bx = '{9'd20,  9'd50,  12'd1224, 12'd3060, 12'd1224, 12'd3060};
            4'd4:    bx = '{9'd260, 9'd300, 12'd918,  12'd3060, 12'd918,  12'd3060};
            4'd5:    bx = '{9'd50,  9'd80,  12'd1224, 12'd3060, 12'd1530, 12'd3060};
            4'd6:    bx = '{9'd300, 9'd340, 12'd918,  12'd3060, 12'd1224, 12'd3060};
            4'd7:    bx = '{9'd160, 9'd200, 12'd1224, 12'd3060, 12'd1224, 12'd3060};
            4'd8:    bx = '{9'd0,   9'd360, 12'd0,    12'd3060, 12'd0,    12'd765};
            4'd9:    bx = '{9'd0,   9'd360, 12'd0,    12'd918,  12'd2448, 12'd3060};
            4'd10:   bx = '{9'd0,   9'd360, 12'd0,    12'd459,  12'd765,  12'd2448};
            4'd11:   bx = '{9'd25,  9'd45,  12'd612,  12'd2142, 12'd918,  12'd2142};
            default: bx = '{9'd0,   9'd0,   12'd0,    12'd0,    12'd0,    12'd0};
        endcase
        return bx;
    endfunction

    function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [11:0] edge_dist(input logic [11:0] v, input logic [11:0] lo,
                                              input logic [11:0] hi);
        logic [11:0] r;
        if (v < lo)
        begin
            r = lo - v;
        end
        else if (v > hi)
        begin
            r = v - hi;
        end
        else
        begin
            r = 12'd0;
        end
        return r;
    endfunction

endpackage

// ===== hdl/hcgc_front.sv =====
`timescale 1ns / 1ps
module hcgc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hcgc_pkg::in_item_t in_data,
    output logic               q_valid,
    output hcgc_pkg::work_t    q_data,
    input  logic               q_pop
);

    hcgc_pkg::work_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            push;
    hcgc_pkg::work_t conv;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = entry_reg[rd_ptr_reg];

    // scale 8-bit channels to 1/3060 units
    always_comb
    begin
        conv.hue    = in_data.hue;
        conv.sat12  = 12'(in_data.saturation) * 12'd12;
        conv.bri12  = 12'(in_data.brightness) * 12'd12;
        conv.weight = in_data.weight;
        conv.last   = in_data.last;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= conv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/hcgc_back.sv =====
`timescale 1ns / 1ps
module hcgc_back #(
    parameter int NUM_GROUPS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  hcgc_pkg::work_t               q_data,
    output logic                          q_pop,
    input  logic [hcgc_pkg::SCORE_W-1:0]  threshold,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hcgc_pkg::out_item_t           out_data
);

    localparam int NG_EFF = (NUM_GROUPS < hcgc_pkg::TABLE_SIZE) ? NUM_GROUPS
                                                                : hcgc_pkg::TABLE_SIZE;
    localparam int GW     = (NG_EFF > 1) ? $clog2(NG_EFF) : 1;
    localparam int SUM_W  = hcgc_pkg::SUM_W;
    localparam int TOT_W  = hcgc_pkg::TOT_W;
    localparam int SW     = hcgc_pkg::SCORE_W;
    localparam logic [GW-1:0] G_LAST = GW'(NG_EFF - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCORE  = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DLOAD  = 3'd3;
    localparam logic [2:0] ST_DSTEP  = 3'd4;
    localparam logic [2:0] ST_DCMP   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]        state_reg;
    hcgc_pkg::work_t   cur_reg;
    logic [GW-1:0]     g_reg;
    logic [SUM_W-1:0]  sums_reg [NG_EFF];
    logic [TOT_W-1:0]  total_reg;

    // scoring pipeline
    logic              p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    logic [GW-1:0]     p1_g_reg, p2_g_reg, p3_g_reg, p4_g_reg;
    logic              p1_full_reg, p2_full_reg;
    logic              p1_zero_reg, p2_zero_reg;
    logic [hcgc_pkg::DIFF_W-1:0] p1_diff_reg;
    logic [hcgc_pkg::NUM_W-1:0]  p2_num_reg;
    logic [SW-1:0]     p2_q0_reg;
    logic [SW-1:0]     p3_score_reg;
    logic [SUM_W-1:0]  p4_add_reg;

    // division
    logic [GW-1:0]     div_g_reg;
    logic [4:0]        step_reg;
    logic [TOT_W-1:0]  rem_reg;
    logic [SW-1:0]     shf_reg;
    logic [SW-1:0]     quo_reg;
    logic [SW-1:0]     best_reg;
    logic [3:0]        best_idx_reg;

    logic                 out_valid_reg;
    hcgc_pkg::out_item_t  out_data_reg;

    // stage 1 logic
    hcgc_pkg::box_t    bx;
    logic              s1_full, s1_zero;
    logic [hcgc_pkg::DIFF_W-1:0] s1_diff;
    // stage 2 and 3
    logic [hcgc_pkg::NUM_W-1:0]  s2_num;
    logic [59:0]       s2_prod;
    logic [30:0]       s3_rem;
    logic [SW-1:0]     s3_score;
    // accumulate and divide
    logic [GW-1:0]     rd_idx;
    logic [SUM_W-1:0]  rd_sum;
    logic [SUM_W:0]    acc;
    logic [SUM_W-1:0]  acc_sat;
    logic [TOT_W:0]    tot_acc;
    logic [TOT_W:0]    trial;
    logic [SW-1:0]     avg;
    logic              out_take;
    logic              pipe_busy;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_take  = out_valid_reg && !out_stall;
    assign pipe_busy = p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg;

    always_comb
    begin
        logic [9:0]  h;
        logic        wrap, inhue;
        logic [9:0]  hd, t;
        logic [14:0] d;
        bx    = hcgc_pkg::get_box(4'(g_reg));
        h     = {1'b0, cur_reg.hue};
        wrap  = bx.hlo > bx.hhi;
        inhue = wrap ? (cur_reg.hue >= bx.hlo || cur_reg.hue <= bx.hhi)
                     : (cur_reg.hue >= bx.hlo && cur_reg.hue <= bx.hhi);
        hd = hcgc_pkg::abs_diff(h, {1'b0, bx.hlo});
        t  = hcgc_pkg::abs_diff(h, {1'b0, bx.hhi});
        if (t < hd)
        begin
            hd = t;
        end
        if (wrap)
        begin
            t = hcgc_pkg::abs_diff(h + hcgc_pkg::FULL_TURN, {1'b0, bx.hlo});
            if (t < hd)
            begin
                hd = t;
            end
            t = hcgc_pkg::abs_diff(h, {1'b0, bx.hhi} + hcgc_pkg::FULL_TURN);
            if (t < hd)
            begin
                hd = t;
            end
        end
        d = 15'(hd) * 15'(hcgc_pkg::DEG_UNITS)
            + 15'(hcgc_pkg::edge_dist(cur_reg.sat12, bx.slo, bx.shi))
            + 15'(hcgc_pkg::edge_dist(cur_reg.bri12, bx.blo, bx.bhi));
        s1_full = inhue && cur_reg.sat12 >= bx.slo && cur_reg.sat12 <= bx.shi
                  && cur_reg.bri12 >= bx.blo && cur_reg.bri12 <= bx.bhi;
        s1_zero = d >= hcgc_pkg::SCORE_SPAN;
        s1_diff = s1_zero ? '0 : hcgc_pkg::DIFF_W'(hcgc_pkg::SCORE_SPAN - d);
    end

    always_comb
    begin
        // round half up: divide (span - d) * 65536 + span/2 by span via reciprocal
        s2_num  = {p1_diff_reg, 16'd0} + hcgc_pkg::NUM_W'(hcgc_pkg::HALF_SPAN);
        s2_prod = 60'(s2_num) * 60'(hcgc_pkg::RECIP_M);
        s3_rem  = 31'(p2_num_reg) - 31'(p2_q0_reg) * 31'(hcgc_pkg::SCORE_SPAN);
        if (p2_full_reg)
        begin
            s3_score = hcgc_pkg::ONE_Q16;
        end
        else if (p2_zero_reg)
        begin
            s3_score = '0;
        end
        else if (s3_rem >= 31'(hcgc_pkg::SCORE_SPAN))
        begin
            s3_score = p2_q0_reg + 1'b1;
        end
        else
        begin
            s3_score = p2_q0_reg;
        end
    end

    always_comb
    begin
        rd_idx  = (state_reg == ST_DLOAD) ? div_g_reg : p4_g_reg;
        rd_sum  = sums_reg[rd_idx];
        acc     = {1'b0, rd_sum} + {1'b0, p4_add_reg};
        acc_sat = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
        tot_acc = {1'b0, total_reg} + (TOT_W + 1)'(q_data.weight);
        trial   = {rem_reg, shf_reg[SW-1]};
        avg     = (quo_reg > hcgc_pkg::ONE_Q16) ? hcgc_pkg::ONE_Q16 : quo_reg;
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        p1_g_reg     <= g_reg;
        p1_full_reg  <= s1_full;
        p1_zero_reg  <= s1_zero;
        p1_diff_reg  <= s1_diff;
        p2_g_reg     <= p1_g_reg;
        p2_full_reg  <= p1_full_reg;
        p2_zero_reg  <= p1_zero_reg;
        p2_num_reg   <= s2_num;
        p2_q0_reg    <= s2_prod[hcgc_pkg::RECIP_SHIFT +: SW];
        p3_g_reg     <= p2_g_reg;
        p3_score_reg <= s3_score;
        p4_g_reg     <= p3_g_reg;
        p4_add_reg   <= SUM_W'(cur_reg.weight) * SUM_W'(p3_score_reg);
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            g_reg         <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            p4_v_reg      <= 1'b0;
            total_reg     <= '0;
            for (int i = 0; i < NG_EFF; i++)
            begin
                sums_reg[i] <= '0;
            end
            div_g_reg     <= '0;
            step_reg      <= '0;
            rem_reg       <= '0;
            shf_reg       <= '0;
            quo_reg       <= '0;
            best_reg      <= '0;
            best_idx_reg  <= hcgc_pkg::MISC_CODE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            p1_v_reg <= (state_reg == ST_SCORE);
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
            if (p4_v_reg)
            begin
                sums_reg[p4_g_reg] <= acc_sat;
            end
            // the finish state drives the output register itself
            if (out_take && state_reg != ST_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        total_reg <= tot_acc[TOT_W] ? '1 : tot_acc[TOT_W-1:0];
                        g_reg     <= '0;
                        state_reg <= ST_SCORE;
                    end
                end
                ST_SCORE:
                begin
                    if (g_reg == G_LAST)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        g_reg <= g_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        if (cur_reg.last)
                        begin
                            div_g_reg    <= '0;
                            best_reg     <= '0;
                            best_idx_reg <= hcgc_pkg::MISC_CODE;
                            state_reg    <= ST_DLOAD;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DLOAD:
                begin
                    rem_reg  <= TOT_W'(rd_sum[SUM_W-1:SW]);
                    shf_reg  <= rd_sum[SW-1:0];
                    step_reg <= '0;
                    if (total_reg == '0)
                    begin
                        quo_reg   <= '0;
                        state_reg <= ST_DCMP;
                    end
                    else if ((TOT_W + 1)'(rd_sum[SUM_W-1:SW]) >= (TOT_W + 1)'(total_reg))
                    begin
                        // quotient would reach 2^17: capped anyway
                        quo_reg   <= hcgc_pkg::ONE_Q16;
                        state_reg <= ST_DCMP;
                    end
                    else
                    begin
                        quo_reg   <= '0;
                        state_reg <= ST_DSTEP;
                    end
                end
                ST_DSTEP:
                begin
                    if (trial >= {1'b0, total_reg})
                    begin
                        rem_reg <= TOT_W'(trial - {1'b0, total_reg});
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[TOT_W-1:0];
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    shf_reg  <= {shf_reg[SW-2:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(SW - 1))
                    begin
                        state_reg <= ST_DCMP;
                    end
                end
                ST_DCMP:
                begin
                    if (avg > best_reg)
                    begin
                        best_reg     <= avg;
                        best_idx_reg <= 4'(div_g_reg);
                    end
                    if (div_g_reg == G_LAST)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        div_g_reg <= div_g_reg + 1'b1;
                        state_reg <= ST_DLOAD;
                    end
                end
                ST_FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg.group_index <= (best_reg < threshold)
                                                    ? hcgc_pkg::MISC_CODE : best_idx_reg;
                        out_data_reg.score <= best_reg;
                        total_reg <= '0;
                        for (int i = 0; i < NG_EFF; i++)
                        begin
                            sums_reg[i] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/hsv_color_group_classifier_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload               Handshake
// in       input      hcgc_pkg::in_item_t   in_valid / in_stall
// out      output     hcgc_pkg::out_item_t  out_valid / out_stall
// cfg      input      misc_threshold Q1.16  cfg_write / cfg_data
//
// A colour takes one issue slot per group through the
// shared four-stage scorer, then the drain of that scorer.
// After a last colour, the bit-serial divider gives
// one quotient bit a cycle for each group average, then the result loads.
// Reset clears the queue, the sums and the total, and sets the threshold to 19661.
// A two-entry queue keeps accepting while the back end works, until it is full; the result
// register holds under out_stall and only blocks the next last colour.
module hsv_color_group_classifier_core #(
    parameter int NUM_GROUPS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hcgc_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hcgc_pkg::out_item_t           out_data,
    input  logic                          cfg_write,
    input  logic [hcgc_pkg::SCORE_W-1:0]  cfg_data
);

    logic                          q_valid;
    logic                          q_pop;
    hcgc_pkg::work_t               q_data;
    logic [hcgc_pkg::SCORE_W-1:0]  threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 17'd19661;
        end
        else if (cfg_write)
        begin
            threshold_reg <= cfg_data;
        end
    end

    hcgc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    hcgc_back #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .threshold (threshold_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/hcgc_checker.sv =====
`timescale 1ns / 1ps
`include "hsv_color_group_classifier_core_assert.svh"
module hcgc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input hcgc_pkg::out_item_t out_data
);

    `HCGC_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `HCGC_IMPLY(a_index_range, out_valid, out_data.group_index <= hcgc_pkg::MISC_CODE)
    `HCGC_IMPLY(a_score_range, out_valid, out_data.score <= hcgc_pkg::ONE_Q16)
    `HCGC_IMPLY(a_group_scored, out_valid && out_data.group_index != hcgc_pkg::MISC_CODE,
                out_data.score != '0)

endmodule

bind hsv_color_group_classifier_core hcgc_checker u_hcgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ===== test/hsv_color_group_classifier_core_tb.sv =====
`timescale 1ns / 1ps
module hsv_color_group_classifier_core_tb;

    localparam int N_GROUPS = 12;
    localparam longint SUM_CAP = (64'd1 << (hcgc_pkg::WEIGHT_BITS + 17)) - 1;
    localparam longint TOT_CAP = (64'd1 << (hcgc_pkg::WEIGHT_BITS + 3)) - 1;
    localparam int SPAN = 9180;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    class group_scoreboard;
        longint group_sum[N_GROUPS];
        longint weight_sum;
        int unsigned threshold;
        hcgc_pkg::out_item_t pending[$];
        int errors;

        function new();
            threshold = 19661;
            errors = 0;
            clear_totals();
        endfunction

        function void clear_totals();
            foreach (group_sum[g])
            begin
                group_sum[g] = 0;
            end
            weight_sum = 0;
        endfunction

        function int box_score(int g, int h, int s, int b);
            int hlo, hhi, slo, shi, blo, bhi, hd, d, t;
            bit wrap, inhue;
            int tab[N_GROUPS][6] = '{
                '{200, 260, 918, 3060, 918, 3060}, '{340, 20, 918, 3060, 918, 3060},
                '{80, 140, 918, 3060, 918, 3060}, '{20, 50, 1224, 3060, 1224, 3060},
                '{260, 300, 918, 3060, 918, 3060}, '{50, 80, 1224, 3060, 1530, 3060},
                '{300, 340, 918, 3060, 1224, 3060}, '{160, 200, 1224, 3060, 1224, 3060},
                '{0, 360, 0, 3060, 0, 765}, '{0, 360, 0, 918, 2448, 3060},
                '{0, 360, 0, 459, 765, 2448}, '{25, 45, 612, 2142, 918, 2142}};
            hlo = tab[g][0]; hhi = tab[g][1]; slo = tab[g][2];
            shi = tab[g][3]; blo = tab[g][4]; bhi = tab[g][5];
            wrap = hlo > hhi;
            inhue = wrap ? (h >= hlo || h <= hhi) : (h >= hlo && h <= hhi);
            if (inhue && s >= slo && s <= shi && b >= blo && b <= bhi)
            begin
                return 65536;
            end
            hd = (h > hlo) ? h - hlo : hlo - h;
            t = (h > hhi) ? h - hhi : hhi - h;
            if (t < hd) hd = t;
            if (wrap)
            begin
                t = h - (hlo - 360);
                if (t < hd) hd = t;
                t = (hhi + 360) - h;
                if (t < 0) t = -t;
                if (t < hd) hd = t;
            end
            d = hd * 17;
            if (s < slo) d += slo - s; else if (s > shi) d += s - shi;
            if (b < blo) d += blo - b; else if (b > bhi) d += b - bhi;
            if (d >= SPAN) return 0;
            return int'((longint'(SPAN - d) * 65536 + SPAN / 2) / SPAN);
        endfunction

        function void note_colour(hcgc_pkg::in_item_t it);
            longint avg, best;
            hcgc_pkg::out_item_t r;
            for (int g = 0; g < N_GROUPS; g++)
            begin
                group_sum[g] += longint'(it.weight)
                    * box_score(g, it.hue, it.saturation * 12, it.brightness * 12);
                if (group_sum[g] > SUM_CAP) group_sum[g] = SUM_CAP;
            end
            weight_sum += it.weight;
            if (weight_sum > TOT_CAP) weight_sum = TOT_CAP;
            if (!it.last) return;
            best = 0;
            r.group_index = hcgc_pkg::MISC_CODE;
            for (int g = 0; g < N_GROUPS; g++)
            begin
                avg = 0;
                if (weight_sum != 0)
                begin
                    avg = group_sum[g] / weight_sum;
                    if (avg > 65536) avg = 65536;
                end
                if (avg > best)
                begin
                    best = avg;
                    r.group_index = 4'(g);
                end
            end
            if (best < threshold) r.group_index = hcgc_pkg::MISC_CODE;
            r.score = 17'(best);
            pending.insert(pending.size(), r);
            clear_totals();
        endfunction

        function void check_result(hcgc_pkg::out_item_t got);
            hcgc_pkg::out_item_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result idx=%0d score=%0d", $time,
                         got.group_index, got.score);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.group_index !== exp_r.group_index)
            begin
                $display("%0t: group_index expected %0d actual %0d", $time,
                         exp_r.group_index, got.group_index);
                errors++;
            end
            if (got.score !== exp_r.score)
            begin
                $display("%0t: score expected %0d actual %0d", $time,
                         exp_r.score, got.score);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, cfg_write;
    hcgc_pkg::in_item_t in_data;
    hcgc_pkg::out_item_t out_data;
    logic [hcgc_pkg::SCORE_W-1:0] cfg_data;

    group_scoreboard sb;
    int cycle_count;
    bit long_hold;
    bit quiet_out;

    hsv_color_group_classifier_core #(.NUM_GROUPS(N_GROUPS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hsv_color_group_classifier_core_tb: FAIL");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(out_data);
        end
    end

    // receiver: random stall per transaction, a long hold when asked
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (600) @(negedge clk);
                long_hold = 0;
            end
            gap = quiet_out ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // valid stays high between back-to-back transactions; drop it on idle cycles
    task automatic send_colour(hcgc_pkg::in_item_t it, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_colour(it);
        @(negedge clk);
    endtask

    task automatic make_colour(output hcgc_pkg::in_item_t it, input bit last);
        it.hue = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(360, 511))
                                                : 9'($urandom_range(0, 359));
        it.saturation = 8'($urandom);
        it.brightness = 8'($urandom);
        case ($urandom_range(0, 4))
            0: it.weight = 19'($urandom);
            1: it.weight = '1;
            2: it.weight = '0;
            default: it.weight = 19'($urandom_range(0, 4000));
        endcase
        it.last = last;
    endtask

    task automatic drain_then_write(logic [hcgc_pkg::SCORE_W-1:0] thr);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_data <= thr;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.threshold = thr;
    endtask

    initial
    begin
        hcgc_pkg::in_item_t it;
        int len;
        int sent;
        logic [hcgc_pkg::SCORE_W-1:0] thr_set[5] = '{17'd0, 17'd65536, 17'd19661, 17'd1,
                                                    17'd40000};
        sb = new();
        cycle_count = 0;
        long_hold = 0;
        quiet_out = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: box centres, edges, wrap hues, weight extremes, zero total
        send_colour('{9'd230, 8'd200, 8'd200, 19'd100, 1'b1}, 0);
        send_colour('{9'd0, 8'd255, 8'd255, '1, 1'b0}, 0);
        send_colour('{9'd359, 8'd255, 8'd255, '1, 1'b0}, 0);
        send_colour('{9'd340, 8'd77, 8'd77, '1, 1'b1}, 0);
        send_colour('{9'd20, 8'd0, 8'd0, 19'd0, 1'b1}, 0);
        send_colour('{9'd511, 8'd0, 8'd0, 19'd5, 1'b1}, 0);
        send_colour('{9'd360, 8'd10, 8'd10, 19'd5, 1'b1}, 0);
        send_colour('{9'd35, 8'd100, 8'd120, 19'd7, 1'b0}, 0);
        send_colour('{9'd60, 8'd110, 8'd130, 19'd7, 1'b1}, 0);
        send_colour('{9'd170, 8'd20, 8'd150, 19'd300, 1'b1}, 0);
        send_colour('{9'd110, 8'd255, 8'd0, 19'd1, 1'b1}, 0);
        for (int k = 0; k < 12; k++)
        begin
            send_colour('{9'h155, 8'hAA, 8'h55, 19'h2AAAA, 1'b0}, 0);
        end
        send_colour('{9'h0AA, 8'h55, 8'hAA, 19'h55555, 1'b1}, 0);

        sent = 0;
        for (int phase = 0; phase < 5; phase++)
        begin
            drain_then_write(thr_set[phase]);
            if (phase == 2)
            begin
                // back-to-back last colours while the receiver holds
                long_hold = 1;
                for (int k = 0; k < 12; k++)
                begin
                    make_colour(it, 1'b1);
                    send_colour(it, 1);
                    sent++;
                end
            end
            quiet_out = (phase == 3);
            while (sent < (phase + 1) * 310)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    make_colour(it, k == len - 1);
                    send_colour(it, phase == 3 && $urandom_range(0, 1));
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("hsv_color_group_classifier_core_tb: PASS");
        end
        else
        begin
            $display("hsv_color_group_classifier_core_tb: FAIL");
        end
        $finish;
    end
endmodule
